// ===== design/colony_life_automaton_top_macros.svh =====
// Assertion macros used by the colony life automaton top level.
`ifndef COLONY_LIFE_AUTOMATON_TOP_MACROS_SVH
`define COLONY_LIFE_AUTOMATON_TOP_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define CLA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("colony life automaton check failed");

// Check a consequence in the cycle after its antecedent.
`define CLA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("colony life automaton check failed");

`endif

// ===== design/cla_pkg.sv =====
// Shared types, constants and helpers of the colony life automaton.
`timescale 1ns / 1ps
package cla_pkg;

	localparam int MAX_WIDTH     = 64;
	localparam int MAX_HEIGHT    = 64;
	localparam int COLONY_BITS   = 4;
	localparam int LIFETIME_BITS = 16;

	localparam int COORD_BITS = 6;
	localparam int DIM_BITS   = 7;
	localparam int ADDR_BITS  = 2 * COORD_BITS;
	localparam int MEM_DEPTH  = 1 << ADDR_BITS;
	localparam int CNT_BITS   = 13;
	localparam int REM_CNT_BITS = $clog2(COORD_BITS + 1);

	localparam int NBR_TAPS   = 9;
	localparam int CENTER_TAP = 4;
	localparam int TOT_BITS   = 4;
	localparam int PH_BITS    = 4;
	localparam logic [PH_BITS-1:0] PH_READ_LAST = PH_BITS'(NBR_TAPS - 1);
	localparam logic [PH_BITS-1:0] PH_CENTER    = PH_BITS'(CENTER_TAP + 1);
	localparam logic [PH_BITS-1:0] PH_LAST      = PH_BITS'(NBR_TAPS + 1);

	localparam logic [LIFETIME_BITS-1:0] LIFE_MAX = '1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic                     alive;
		logic                     obstacle;
		logic [COLONY_BITS-1:0]   colony;
		logic [LIFETIME_BITS-1:0] life;
	} cell_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [5:0]  col_x;
		logic [5:0]  row_y;
		logic        new_alive;
		logic        new_obstacle;
		logic [3:0]  new_colony;
		logic [15:0] new_livetime;
	} in_item_t;

	typedef struct packed {
		logic        read_alive;
		logic        read_obstacle;
		logic [3:0]  read_colony;
		logic [15:0] read_livetime;
		logic [12:0] changed_count;
		logic [12:0] alive_count;
	} out_item_t;

	typedef struct packed {
		logic [TOT_BITS-1:0]    total;
		logic [COLONY_BITS-1:0] best;
	} win_res_t;

	// Zero acts as one, anything above the maximum acts as the maximum.
	function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] v,
			input logic [DIM_BITS-1:0] maxv);
		logic [DIM_BITS-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_BITS'(1);
		else if (v > maxv)
			r = maxv;
		return r;
	endfunction

endpackage

// ===== design/cla_ifs.sv =====
// Valid/ready channel interfaces for input and result transactions.
`timescale 1ns / 1ps
interface cla_in_if;
	logic              valid;
	logic              ready;
	cla_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface cla_out_if;
	logic               valid;
	logic               ready;
	cla_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/cla_rem_unit.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module cla_rem_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [cla_pkg::COORD_BITS-1:0]  dividend,
	input  logic [cla_pkg::DIM_BITS-1:0]    divisor,
	output logic                            done,
	output logic [cla_pkg::COORD_BITS-1:0]  rem
);

	logic [cla_pkg::DIM_BITS-1:0]     r_q;
	logic [cla_pkg::COORD_BITS-1:0]   q_q;
	logic [cla_pkg::REM_CNT_BITS-1:0] cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic [cla_pkg::DIM_BITS-1:0]     trial;
	logic [cla_pkg::DIM_BITS-1:0]     sub;

	assign trial = {r_q[cla_pkg::DIM_BITS-2:0], q_q[cla_pkg::COORD_BITS-1]};
	assign sub   = (trial >= divisor) ? trial - divisor : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= cla_pkg::REM_CNT_BITS'(cla_pkg::COORD_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == cla_pkg::REM_CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			q_q <= dividend;
		end else if (busy_q) begin
			r_q <= sub;
			q_q <= {q_q[cla_pkg::COORD_BITS-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = r_q[cla_pkg::COORD_BITS-1:0];

endmodule

// ===== design/cla_nbr_cell.sv =====
// One tap of the neighborhood chain: holds a cell's alive flag and colony.
`timescale 1ns / 1ps
module cla_nbr_cell (
	input  logic                            clk,
	input  logic                            shift_en,
	input  logic                            d_alive,
	input  logic [cla_pkg::COLONY_BITS-1:0] d_colony,
	output logic                            q_alive,
	output logic [cla_pkg::COLONY_BITS-1:0] q_colony
);

	logic                            alive_q;
	logic [cla_pkg::COLONY_BITS-1:0] colony_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			alive_q  <= d_alive;
			colony_q <= d_colony;
		end
	end

	assign q_alive  = alive_q;
	assign q_colony = colony_q;

endmodule

// ===== design/cla_window.sv =====
// Chain of nine neighborhood taps with live count and majority colony.
`timescale 1ns / 1ps
module cla_window (
	input  logic                            clk,
	input  logic                            shift_en,
	input  logic                            d_alive,
	input  logic [cla_pkg::COLONY_BITS-1:0] d_colony,
	output cla_pkg::win_res_t               res
);

	logic                            tap_alive  [cla_pkg::NBR_TAPS+1];
	logic [cla_pkg::COLONY_BITS-1:0] tap_colony [cla_pkg::NBR_TAPS+1];

	assign tap_alive[0]  = d_alive;
	assign tap_colony[0] = d_colony;

	for (genvar g = 0; g < cla_pkg::NBR_TAPS; g++) begin : g_tap
		cla_nbr_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.d_alive  (tap_alive[g]),
			.d_colony (tap_colony[g]),
			.q_alive  (tap_alive[g+1]),
			.q_colony (tap_colony[g+1])
		);
	end

	// With exactly three live neighbors, a colony seen twice wins outright,
	// otherwise the lowest of the three wins.
	always_comb begin
		logic [cla_pkg::TOT_BITS-1:0]    tot;
		logic [cla_pkg::COLONY_BITS-1:0] ca;
		logic [cla_pkg::COLONY_BITS-1:0] cb;
		logic [cla_pkg::COLONY_BITS-1:0] cc;
		logic [cla_pkg::COLONY_BITS-1:0] lo;
		tot = '0;
		ca  = '0;
		cb  = '0;
		cc  = '0;
		for (int j = 1; j <= cla_pkg::NBR_TAPS; j++) begin
			if (j != cla_pkg::CENTER_TAP + 1 && tap_alive[j]) begin
				if (tot == cla_pkg::TOT_BITS'(0))
					ca = tap_colony[j];
				else if (tot == cla_pkg::TOT_BITS'(1))
					cb = tap_colony[j];
				else if (tot == cla_pkg::TOT_BITS'(2))
					cc = tap_colony[j];
				tot = tot + 1'b1;
			end
		end
		lo = (ca < cb) ? ca : cb;
		lo = (cc < lo) ? cc : lo;
		res.total = tot;
		if (ca == cb || ca == cc)
			res.best = ca;
		else if (cb == cc)
			res.best = cb;
		else
			res.best = lo;
	end

endmodule

// ===== design/colony_life_automaton_top.sv =====
// Top level of the colony life automaton: cell store, snapshot and step sequencer.
`timescale 1ns / 1ps
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+---------------------------------------------
//  in_ch     | in  | valid/ready   | opcode, col_x, row_y, new_* cell fields
//  out_ch    | out | valid/ready   | read_* cell fields, changed_count, alive_count
//  cfg       | in  | cfg_we only   | cfg_idx selects grid_width / grid_height
//
//  Sequence: a read or write first finds the column/row wrap remainder in the
//  bit-serial remainder units, then does one store read, one update, and loads the
//  result register. The unused opcode goes straight to loading the result register.
//  A step copies the store into the snapshot memory, then every cell streams its
//  nine snapshot neighbors through the tap chain, then the result register loads.
//  Reset: after arst_n is released a clearing pass writes zero cells over all
//  4096 store entries and holds in_ch.ready low meanwhile.
//  Stalls: the result register lets in_ch take a new transaction while a result
//  waits; a finished result stalls only while the register is still occupied.
module colony_life_automaton_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [cla_pkg::DIM_BITS-1:0]  cfg_wdata,
	cla_in_if.sink                        in_ch,
	cla_out_if.source                     out_ch
);

`include "colony_life_automaton_top_macros.svh"

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_ACC,
		S_FIN,
		S_COPY,
		S_CALC
	} state_t;

	localparam int CW = cla_pkg::COORD_BITS;
	localparam int AW = cla_pkg::ADDR_BITS;

	state_t                         state_q;
	logic [AW:0]                    idx_q;
	cla_pkg::in_item_t              item_q;
	logic [cla_pkg::CNT_BITS-1:0]   live_q;
	logic [cla_pkg::CNT_BITS-1:0]   chg_q;
	cla_pkg::out_item_t             res_q;
	cla_pkg::out_item_t             out_q;
	logic                           out_vld_q;
	logic [cla_pkg::DIM_BITS-1:0]   width_q;
	logic [cla_pkg::DIM_BITS-1:0]   height_q;
	logic [CW-1:0]                  x_q;
	logic [CW-1:0]                  y_q;
	logic [cla_pkg::PH_BITS-1:0]    ph_q;
	cla_pkg::cell_t                 ctr_q;
	cla_pkg::cell_t                 rd_q;
	cla_pkg::cell_t                 sd_q;

	// Cell store and the snapshot taken at the start of each step.
	cla_pkg::cell_t store_mem [cla_pkg::MEM_DEPTH];
	cla_pkg::cell_t snap_mem  [cla_pkg::MEM_DEPTH];

	logic                 st_we, st_re, sn_we, sn_re;
	logic [AW-1:0]        st_wa, st_ra, sn_wa, sn_ra;
	cla_pkg::cell_t       st_wd;

	logic [cla_pkg::DIM_BITS-1:0] eff_w, eff_h;
	logic                 in_acc;
	logic                 fin_load;
	logic                 rem_start;
	logic                 rx_done, ry_done;
	logic [CW-1:0]        rx, ry;
	logic [CW-1:0]        xm, xp, ym, yp, nb_x, nb_y;
	logic                 x_last, y_last;
	cla_pkg::win_res_t    win;
	logic                 win_shift;
	logic                 born, surv, nalive;
	logic [cla_pkg::LIFETIME_BITS-1:0] life_inc;
	cla_pkg::cell_t       calc_cell;
	cla_pkg::cell_t       wr_cell;
	logic [cla_pkg::CNT_BITS-1:0] calc_live, calc_chg, wr_live;

	// Assemble one result transaction.
	function automatic cla_pkg::out_item_t make_res(input cla_pkg::cell_t c,
			input logic [cla_pkg::CNT_BITS-1:0] chg,
			input logic [cla_pkg::CNT_BITS-1:0] live);
		cla_pkg::out_item_t r;
		r.read_alive    = c.alive;
		r.read_obstacle = c.obstacle;
		r.read_colony   = c.colony;
		r.read_livetime = c.life;
		r.changed_count = chg;
		r.alive_count   = live;
		return r;
	endfunction

	assign eff_w  = cla_pkg::eff_dim(width_q, cla_pkg::DIM_BITS'(cla_pkg::MAX_WIDTH));
	assign eff_h  = cla_pkg::eff_dim(height_q, cla_pkg::DIM_BITS'(cla_pkg::MAX_HEIGHT));
	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign fin_load = (state_q == S_FIN) && (!out_vld_q || out_ch.ready);
	assign rem_start = in_acc && (in_ch.payload.opcode == cla_pkg::OP_WRITE ||
		in_ch.payload.opcode == cla_pkg::OP_READ);

	cla_rem_unit u_rem_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (in_ch.payload.col_x),
		.divisor  (eff_w),
		.done     (rx_done),
		.rem      (rx)
	);

	cla_rem_unit u_rem_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (in_ch.payload.row_y),
		.divisor  (eff_h),
		.done     (ry_done),
		.rem      (ry)
	);

	// Toroidal neighbor coordinates of the cell being updated.
	assign x_last = ({1'b0, x_q} + 1'b1) >= eff_w;
	assign y_last = ({1'b0, y_q} + 1'b1) >= eff_h;
	assign xm = (x_q == '0) ? CW'(eff_w - 1'b1) : x_q - 1'b1;
	assign xp = x_last ? '0 : x_q + 1'b1;
	assign ym = (y_q == '0) ? CW'(eff_h - 1'b1) : y_q - 1'b1;
	assign yp = y_last ? '0 : y_q + 1'b1;

	// Phase picks the neighbor: rows above, same, below; columns left, same, right.
	always_comb begin
		unique case (ph_q) inside
			4'd0, 4'd1, 4'd2: nb_y = ym;
			4'd3, 4'd4, 4'd5: nb_y = y_q;
			default:          nb_y = yp;
		endcase
		unique case (ph_q) inside
			4'd0, 4'd3, 4'd6: nb_x = xm;
			4'd1, 4'd4, 4'd7: nb_x = x_q;
			default:          nb_x = xp;
		endcase
	end

	assign win_shift = (state_q == S_CALC) && (ph_q != '0) && (ph_q != cla_pkg::PH_LAST);

	cla_window u_window (
		.clk      (clk),
		.shift_en (win_shift),
		.d_alive  (sd_q.alive),
		.d_colony (sd_q.colony),
		.res      (win)
	);

	// B3/S23 update of the center cell.
	assign born   = !ctr_q.alive && (win.total == cla_pkg::TOT_BITS'(3));
	assign surv   = ctr_q.alive && (win.total == cla_pkg::TOT_BITS'(2) ||
		win.total == cla_pkg::TOT_BITS'(3));
	assign nalive = born || surv;
	assign life_inc = (ctr_q.life == cla_pkg::LIFE_MAX) ? ctr_q.life : ctr_q.life + 1'b1;

	always_comb begin
		calc_cell.alive    = nalive;
		calc_cell.obstacle = 1'b0;
		calc_cell.colony   = born ? win.best : ctr_q.colony;
		calc_cell.life     = nalive ? life_inc : '0;
	end

	assign calc_live = live_q + ((!ctr_q.obstacle && nalive) ? 1'b1 : 1'b0);
	assign calc_chg  = chg_q + ((!ctr_q.obstacle && (nalive != ctr_q.alive)) ? 1'b1 : 1'b0);

	always_comb begin
		wr_cell.alive    = item_q.new_alive;
		wr_cell.obstacle = item_q.new_obstacle;
		wr_cell.colony   = item_q.new_colony;
		wr_cell.life     = item_q.new_livetime;
		wr_live = live_q;
		if (item_q.new_alive && !rd_q.alive)
			wr_live = live_q + 1'b1;
		else if (!item_q.new_alive && rd_q.alive && live_q != '0)
			wr_live = live_q - 1'b1;
	end

	// Memory port steering.
	always_comb begin
		st_we = 1'b0;
		st_wa = idx_q[AW-1:0];
		st_wd = '0;
		st_re = 1'b0;
		st_ra = idx_q[AW-1:0];
		sn_we = 1'b0;
		sn_wa = idx_q[AW-1:0] - 1'b1;
		sn_re = 1'b0;
		sn_ra = {nb_y, nb_x};
		case (state_q)
			S_CLEAR: st_we = 1'b1;
			S_MOD: begin
				st_re = rx_done && ry_done;
				st_ra = {ry, rx};
			end
			S_ACC: begin
				st_we = (item_q.opcode == cla_pkg::OP_WRITE);
				st_wa = {ry, rx};
				st_wd = wr_cell;
			end
			S_COPY: begin
				st_re = !idx_q[AW];
				sn_we = (idx_q != '0);
			end
			S_CALC: begin
				sn_re = (ph_q <= cla_pkg::PH_READ_LAST);
				st_we = (ph_q == cla_pkg::PH_LAST) && !ctr_q.obstacle;
				st_wa = {y_q, x_q};
				st_wd = calc_cell;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we)
			store_mem[st_wa] <= st_wd;
		if (st_re)
			rd_q <= store_mem[st_ra];
	end

	always_ff @(posedge clk) begin
		if (sn_we)
			snap_mem[sn_wa] <= rd_q;
		if (sn_re)
			sd_q <= snap_mem[sn_ra];
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (in_acc)
			item_q <= in_ch.payload;
		if (state_q == S_CALC && ph_q == cla_pkg::PH_CENTER)
			ctr_q <= sd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			idx_q     <= '0;
			live_q    <= '0;
			chg_q     <= '0;
			res_q     <= '0;
			out_q     <= '0;
			out_vld_q <= 1'b0;
			width_q   <= cla_pkg::DIM_BITS'(cla_pkg::MAX_WIDTH);
			height_q  <= cla_pkg::DIM_BITS'(cla_pkg::MAX_HEIGHT);
			x_q       <= '0;
			y_q       <= '0;
			ph_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					cla_pkg::REG_WIDTH:  width_q  <= cfg_wdata;
					cla_pkg::REG_HEIGHT: height_q <= cfg_wdata;
				endcase
			end
			if (fin_load)
				out_vld_q <= 1'b1;
			else if (out_vld_q && out_ch.ready)
				out_vld_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (idx_q[AW-1:0] == '1) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						unique case (in_ch.payload.opcode)
							cla_pkg::OP_STEP: begin
								idx_q   <= '0;
								live_q  <= '0;
								chg_q   <= '0;
								state_q <= S_COPY;
							end
							cla_pkg::OP_NOP: begin
								res_q   <= make_res('0, '0, live_q);
								state_q <= S_FIN;
							end
							default: state_q <= S_MOD;
						endcase
					end
				end
				S_MOD: begin
					if (rx_done && ry_done)
						state_q <= S_ACC;
				end
				S_ACC: begin
					if (item_q.opcode == cla_pkg::OP_WRITE) begin
						live_q <= wr_live;
						res_q  <= make_res('0, '0, wr_live);
					end else begin
						res_q <= make_res(rd_q, '0, live_q);
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_load) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				S_COPY: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q[AW]) begin
						x_q     <= '0;
						y_q     <= '0;
						ph_q    <= '0;
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (ph_q == cla_pkg::PH_LAST) begin
						ph_q   <= '0;
						live_q <= calc_live;
						chg_q  <= calc_chg;
						if (x_last) begin
							x_q <= '0;
							if (y_last) begin
								res_q   <= make_res('0, calc_chg, calc_live);
								state_q <= S_FIN;
							end else begin
								y_q <= y_q + 1'b1;
							end
						end else begin
							x_q <= x_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid   = out_vld_q;
	assign out_ch.payload = out_q;

	`CLA_ASSERT_NOW(a_live_bound, 1'b1, live_q <= cla_pkg::CNT_BITS'(cla_pkg::MEM_DEPTH))
	`CLA_ASSERT_NOW(a_phase_range, state_q == S_CALC, ph_q <= cla_pkg::PH_LAST)
	`CLA_ASSERT_NOW(a_rem_in_grid, state_q == S_ACC, ({1'b0, rx} < eff_w) && ({1'b0, ry} < eff_h))
	`CLA_ASSERT_NEXT(a_step_copies, in_acc && in_ch.payload.opcode == cla_pkg::OP_STEP, state_q == S_COPY)

endmodule
